[hdl/macf_pkg.sv]
// Shared types and constants of the multicast address claim block.
`timescale 1ns / 1ps

package macf_pkg;

  localparam int unsigned MacW       = 48;
  localparam int unsigned CountW     = 16;
  localparam int unsigned KindW      = 4;
  localparam int unsigned TxKindW    = 2;
  localparam int unsigned PhaseW     = 2;
  localparam int unsigned RandW      = 16;
  localparam int unsigned LimitW     = 4;
  localparam int unsigned IntervalW  = 20;
  localparam int unsigned CfgIndexW  = 3;
  localparam int unsigned QueueDepth = 2;

  localparam logic [MacW-1:0]  AddrPrefix = 48'h91E0_F000_0000;
  localparam logic [MacW-1:0]  McastDest  = 48'h91E0_F000_FF00;
  localparam logic [RandW-1:0] RandMaxLow = 16'hFDFF;

  // received message types
  localparam logic [KindW-1:0] RX_KIND_PROBE    = 4'd1;
  localparam logic [KindW-1:0] RX_KIND_DEFEND   = 4'd2;
  localparam logic [KindW-1:0] RX_KIND_ANNOUNCE = 4'd3;

  // transmitted message types
  localparam logic [TxKindW-1:0] TX_KIND_PROBE    = 2'd1;
  localparam logic [TxKindW-1:0] TX_KIND_DEFEND   = 2'd2;
  localparam logic [TxKindW-1:0] TX_KIND_ANNOUNCE = 2'd3;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] REG_PROBE_LIMIT     = 3'd0;
  localparam logic [CfgIndexW-1:0] REG_PROBE_INTERVAL  = 3'd1;
  localparam logic [CfgIndexW-1:0] REG_ANNOUNCE_INTVL  = 3'd2;
  localparam logic [CfgIndexW-1:0] REG_STATION_MAC     = 3'd3;
  localparam logic [CfgIndexW-1:0] REG_ADDRESS_COUNT   = 3'd4;

  // classified operation handed from front to back
  typedef enum logic [1:0] {
    OP_TICK,
    OP_PROBE,
    OP_DEFEND,
    OP_ANNOUNCE
  } op_e;

  typedef struct packed {
    logic [0:0]       action;
    logic [KindW-1:0] rx_kind;
    logic [MacW-1:0]  rx_start_addr;
    logic [CountW-1:0] rx_addr_count;
    logic [MacW-1:0]  rx_sender_mac;
    logic [RandW-1:0] random_low;
  } in_item_t;

  typedef struct packed {
    logic [TxKindW-1:0] tx_kind;
    logic [MacW-1:0]    tx_dest_mac;
    logic [MacW-1:0]    tx_source_mac;
    logic [MacW-1:0]    tx_start_addr;
    logic [CountW-1:0]  tx_addr_count;
    logic [MacW-1:0]    tx_conflict_addr;
    logic [CountW-1:0]  tx_conflict_count;
    logic [PhaseW-1:0]  phase_now;
  } out_item_t;

  typedef struct packed {
    logic [LimitW-1:0]    probe_limit;
    logic [IntervalW-1:0] probe_interval_ticks;
    logic [IntervalW-1:0] announce_interval_ticks;
    logic [MacW-1:0]      station_mac;
    logic [CountW-1:0]    address_count;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [MacW-1:0]   start_addr;
    logic [CountW-1:0] addr_count;
    logic [MacW-1:0]   sender_mac;
    logic [RandW-1:0]  rand_low;
  } queue_item_t;

endpackage

[hdl/macf_front.sv]
// Front end: accepts input beats, classifies them and drops frames of unknown type.
`timescale 1ns / 1ps

module macf_front
  import macf_pkg::*;
(
  input  logic        in_valid_i,
  input  in_item_t    in_item_i,
  output logic        in_ready_o,
  input  logic        queue_full_i,
  output logic        push_o,
  output queue_item_t push_item_o
);

  logic keep;
  op_e  op;

  assign in_ready_o = !queue_full_i;

  always_comb begin
    keep = 1'b1;
    op   = OP_TICK;
    if (in_item_i.action != 1'b0) begin
      unique case (in_item_i.rx_kind)
        RX_KIND_PROBE:    op = OP_PROBE;
        RX_KIND_DEFEND:   op = OP_DEFEND;
        RX_KIND_ANNOUNCE: op = OP_ANNOUNCE;
        default:          keep = 1'b0;
      endcase
    end
  end

  always_comb begin
    push_item_o.op         = op;
    push_item_o.start_addr = in_item_i.rx_start_addr;
    push_item_o.addr_count = in_item_i.rx_addr_count;
    push_item_o.sender_mac = in_item_i.rx_sender_mac;
    // clamp the random value to the top of the usable range
    push_item_o.rand_low   = (in_item_i.random_low > RandMaxLow) ? RandMaxLow
                                                                 : in_item_i.random_low;
  end

  assign push_o = in_valid_i && in_ready_o && keep;

endmodule

[hdl/macf_queue.sv]
// Short queue of classified operations between front and back.
`timescale 1ns / 1ps

module macf_queue
  import macf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  queue_item_t push_item_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        valid_o,
  output queue_item_t item_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  queue_item_t         entry_q [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
    logic [PtrW-1:0] nxt;
    nxt = (ptr == PtrW'(QueueDepth - 1)) ? '0 : ptr + PtrW'(1);
    return nxt;
  endfunction

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hdl/macf_back.sv]
// Back end: claim state machine, interval timer and output register.
`timescale 1ns / 1ps

module macf_back
  import macf_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        q_valid_i,
  input  queue_item_t q_item_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);

  localparam int unsigned LoadW = (TIMER_BITS > IntervalW) ? TIMER_BITS : IntervalW;
  localparam logic [LoadW-1:0] TimerMax = LoadW'({TIMER_BITS{1'b1}});

  typedef enum logic [PhaseW-1:0] {
    PH_INITIAL   = 2'd0,
    PH_PROBING   = 2'd1,
    PH_DEFENDING = 2'd2
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [MacW-1:0]       held_q, held_d;
  logic [LimitW-1:0]     probes_q, probes_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_item_q, out_item_d;

  logic                  can_go;
  logic                  emit;
  logic                  match;
  logic [LimitW-1:0]     probes_dec;
  logic [TIMER_BITS-1:0] probe_load;
  logic [TIMER_BITS-1:0] announce_load;
  logic [TxKindW-1:0]    tx_kind;
  logic [MacW-1:0]       tx_dest;
  logic [MacW-1:0]       cf_addr;
  logic [CountW-1:0]     cf_count;

  // zero interval expires on the next tick; clamp to what the timer holds
  function automatic logic [TIMER_BITS-1:0] timer_load(input logic [IntervalW-1:0] interval);
    logic [LoadW-1:0]      wide;
    logic [TIMER_BITS-1:0] res;
    wide = LoadW'(interval);
    if (wide == '0) begin
      res = TIMER_BITS'(1);
    end else if (wide > TimerMax) begin
      res = TimerMax[TIMER_BITS-1:0];
    end else begin
      res = wide[TIMER_BITS-1:0];
    end
    return res;
  endfunction

  assign probe_load    = timer_load(cfg_i.probe_interval_ticks);
  assign announce_load = timer_load(cfg_i.announce_interval_ticks);

  assign can_go      = !out_valid_q || out_ready_i;
  assign pop_o       = q_valid_i && can_go;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  assign match      = (q_item_i.start_addr == held_q);
  assign probes_dec = (probes_q != '0) ? probes_q - LimitW'(1) : '0;

  always_comb begin
    phase_d  = phase_q;
    held_d   = held_q;
    probes_d = probes_q;
    timer_d  = timer_q;
    emit     = 1'b0;
    tx_kind  = TX_KIND_PROBE;
    tx_dest  = McastDest;
    cf_addr  = '0;
    cf_count = '0;
    if (pop_o) begin
      unique case (q_item_i.op)
        OP_TICK: begin
          if (phase_q != PH_PROBING && phase_q != PH_DEFENDING) begin
            // generate a fresh address and send the first probe
            held_d   = AddrPrefix | MacW'(q_item_i.rand_low);
            probes_d = (cfg_i.probe_limit == '0) ? LimitW'(1) : cfg_i.probe_limit;
            timer_d  = probe_load;
            phase_d  = PH_PROBING;
            emit     = 1'b1;
          end else if (timer_q > TIMER_BITS'(1)) begin
            timer_d = timer_q - TIMER_BITS'(1);
          end else if (phase_q == PH_PROBING) begin
            probes_d = probes_dec;
            emit     = 1'b1;
            if (probes_dec != '0) begin
              timer_d = probe_load;
            end else begin
              timer_d = announce_load;
              phase_d = PH_DEFENDING;
              tx_kind = TX_KIND_ANNOUNCE;
            end
          end else begin
            timer_d = announce_load;
            tx_kind = TX_KIND_ANNOUNCE;
            emit    = 1'b1;
          end
        end
        OP_PROBE, OP_DEFEND, OP_ANNOUNCE: begin
          if (match) begin
            priority if (phase_q == PH_PROBING) begin
              phase_d  = PH_INITIAL;
              probes_d = '0;
              timer_d  = '0;
            end else if (phase_q == PH_DEFENDING) begin
              if (q_item_i.op == OP_PROBE) begin
                // answer the prober directly
                tx_kind  = TX_KIND_DEFEND;
                tx_dest  = q_item_i.sender_mac;
                cf_addr  = q_item_i.start_addr;
                cf_count = q_item_i.addr_count;
                emit     = 1'b1;
              end else begin
                phase_d  = PH_INITIAL;
                probes_d = '0;
                timer_d  = '0;
              end
            end else begin
              phase_d = phase_q;
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (can_go) begin
      out_valid_d = emit;
      if (emit) begin
        out_item_d.tx_kind           = tx_kind;
        out_item_d.tx_dest_mac       = tx_dest;
        out_item_d.tx_source_mac     = cfg_i.station_mac;
        out_item_d.tx_start_addr     = held_d;
        out_item_d.tx_addr_count     = cfg_i.address_count;
        out_item_d.tx_conflict_addr  = cf_addr;
        out_item_d.tx_conflict_count = cf_count;
        out_item_d.phase_now         = phase_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_INITIAL;
      held_q      <= '0;
      probes_q    <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      held_q      <= held_d;
      probes_q    <= probes_d;
      timer_q     <= timer_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

endmodule

[hdl/multicast_address_claim_fsm.sv]
// Top level of the multicast address claim block: configuration registers and datapath.
`timescale 1ns / 1ps

// Takes one input beat per clock (a tick or a received frame) whenever the two-entry
// operation queue has room, and retires one queued operation per clock whenever the
// output register is empty or being emptied; the back end updates the claim state
// for each retired operation, which sets that rate. A frame to send is held in the
// queue and then in the output register. Frames of unknown type are dropped at the
// front end. Configuration writes are taken in every cycle.

module multicast_address_claim_fsm
  import macf_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [MacW-1:0]      cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o
);

  cfg_t        cfg_q, cfg_d;
  logic        queue_full;
  logic        push;
  queue_item_t push_item;
  logic        pop;
  logic        q_valid;
  queue_item_t q_item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PROBE_LIMIT:    cfg_d.probe_limit             = cfg_data_i[LimitW-1:0];
        REG_PROBE_INTERVAL: cfg_d.probe_interval_ticks    = cfg_data_i[IntervalW-1:0];
        REG_ANNOUNCE_INTVL: cfg_d.announce_interval_ticks = cfg_data_i[IntervalW-1:0];
        REG_STATION_MAC:    cfg_d.station_mac             = cfg_data_i;
        REG_ADDRESS_COUNT:  cfg_d.address_count           = cfg_data_i[CountW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.probe_limit             <= LimitW'(3);
      cfg_q.probe_interval_ticks    <= IntervalW'(500);
      cfg_q.announce_interval_ticks <= IntervalW'(30000);
      cfg_q.station_mac             <= '0;
      cfg_q.address_count           <= CountW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  macf_front u_front (
    .in_valid_i   (in_valid_i),
    .in_item_i    (in_item_i),
    .in_ready_o   (in_ready_o),
    .queue_full_i (queue_full),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  macf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (queue_full),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  macf_back #(
    .TIMER_BITS (TIMER_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[tb/sv/multicast_address_claim_fsm_test.sv]
// Self-checking testbench for the multicast address claim block.
`timescale 1ns / 1ps

module multicast_address_claim_fsm_test;
  import macf_pkg::*;

  localparam int unsigned TimerBits   = 20;
  localparam int unsigned HalfPeriod  = 6;
  localparam int unsigned ResetCycles = 10;
  localparam int unsigned PhaseItems  = 260;
  localparam int unsigned CfgDrain    = 8;
  localparam int unsigned EndDrain    = 20;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned MaxGap      = 17;
  localparam int unsigned MaxReports  = 60;

  localparam logic [CfgIndexW-1:0] REG_SPARE_FIRST = REG_ADDRESS_COUNT + 3'd1;
  localparam logic [KindW-1:0]     RX_KIND_NONE    = 4'd0;
  localparam logic [KindW-1:0]     RX_KIND_LAST    = 4'hF;

  typedef enum logic [PhaseW-1:0] {
    PH_INITIAL   = 2'd0,
    PH_PROBING   = 2'd1,
    PH_DEFENDING = 2'd2
  } claim_phase_e;

  class claim_tracker;
    cfg_t                 regs;
    claim_phase_e         claim_phase;
    logic [MacW-1:0]      held_addr;
    logic [LimitW-1:0]    probes_left;
    logic [TimerBits-1:0] wait_timer;
    out_item_t            pending_frames[$];
    int unsigned          errors;

    function new();
      regs.probe_limit             = 4'd3;
      regs.probe_interval_ticks    = 20'd500;
      regs.announce_interval_ticks = 20'd30000;
      regs.station_mac             = '0;
      regs.address_count           = 16'd1;
      claim_phase = PH_INITIAL;
      held_addr   = '0;
      probes_left = '0;
      wait_timer  = '0;
      errors      = 0;
    endfunction

    function void write_register(logic [CfgIndexW-1:0] idx, logic [MacW-1:0] data);
      case (idx)
        REG_PROBE_LIMIT:    regs.probe_limit = data[LimitW-1:0];
        REG_PROBE_INTERVAL: regs.probe_interval_ticks = data[IntervalW-1:0];
        REG_ANNOUNCE_INTVL: regs.announce_interval_ticks = data[IntervalW-1:0];
        REG_STATION_MAC:    regs.station_mac = data;
        REG_ADDRESS_COUNT:  regs.address_count = data[CountW-1:0];
        default: ;
      endcase
    endfunction

    function logic [TimerBits-1:0] reload(logic [IntervalW-1:0] ticks);
      // a zero interval still has to expire, so it counts as one tick
      if (ticks == '0) return TimerBits'(1);
      return TimerBits'(ticks);
    endfunction

    function out_item_t build_frame(logic [TxKindW-1:0] kind, logic [MacW-1:0] dest,
                                    logic [MacW-1:0] caddr, logic [CountW-1:0] ccount);
      out_item_t f;
      f.tx_kind           = kind;
      f.tx_dest_mac       = dest;
      f.tx_source_mac     = regs.station_mac;
      f.tx_start_addr     = held_addr;
      f.tx_addr_count     = regs.address_count;
      f.tx_conflict_addr  = caddr;
      f.tx_conflict_count = ccount;
      f.phase_now         = '0;
      return f;
    endfunction

    function void note_item(in_item_t it);
      out_item_t        f;
      bit               sent;
      bit               known;
      logic [RandW-1:0] low;
      sent = 1'b0;
      if (it.action == 1'b0) begin
        if (claim_phase == PH_INITIAL) begin
          low = (it.random_low > RandMaxLow) ? RandMaxLow : it.random_low;
          held_addr   = AddrPrefix | MacW'(low);
          probes_left = (regs.probe_limit == '0) ? LimitW'(1) : regs.probe_limit;
          wait_timer  = reload(regs.probe_interval_ticks);
          claim_phase = PH_PROBING;
          f = build_frame(TX_KIND_PROBE, McastDest, '0, '0);
          sent = 1'b1;
        end else if (wait_timer > TimerBits'(1)) begin
          wait_timer = wait_timer - TimerBits'(1);
        end else if (claim_phase == PH_PROBING) begin
          // one probe used up per expired interval
          if (probes_left != '0) probes_left = probes_left - LimitW'(1);
          if (probes_left != '0) begin
            wait_timer = reload(regs.probe_interval_ticks);
            f = build_frame(TX_KIND_PROBE, McastDest, '0, '0);
          end else begin
            wait_timer  = reload(regs.announce_interval_ticks);
            claim_phase = PH_DEFENDING;
            f = build_frame(TX_KIND_ANNOUNCE, McastDest, '0, '0);
          end
          sent = 1'b1;
        end else begin
          wait_timer = reload(regs.announce_interval_ticks);
          f = build_frame(TX_KIND_ANNOUNCE, McastDest, '0, '0);
          sent = 1'b1;
        end
      end else begin
        known = (it.rx_kind == RX_KIND_PROBE) || (it.rx_kind == RX_KIND_DEFEND) ||
                (it.rx_kind == RX_KIND_ANNOUNCE);
        if (known && it.rx_start_addr == held_addr) begin
          if (claim_phase == PH_DEFENDING && it.rx_kind == RX_KIND_PROBE) begin
            f = build_frame(TX_KIND_DEFEND, it.rx_sender_mac, it.rx_start_addr,
                            it.rx_addr_count);
            sent = 1'b1;
          end else if (claim_phase != PH_INITIAL) begin
            // drop the claim; the address itself is kept until the next tick
            claim_phase = PH_INITIAL;
            probes_left = '0;
            wait_timer  = '0;
          end
        end
      end
      if (sent) begin
        f.phase_now = claim_phase;
        pending_frames.push_back(f);
      end
    endfunction

    function void report(string what, logic [MacW-1:0] want, logic [MacW-1:0] got);
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_frame(out_item_t got);
      out_item_t want;
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: frame expected none, got %h", $time, got);
        return;
      end
      want = pending_frames.pop_front();
      if (got.tx_kind != want.tx_kind)
        report("tx_kind", MacW'(want.tx_kind), MacW'(got.tx_kind));
      if (got.tx_dest_mac != want.tx_dest_mac)
        report("tx_dest_mac", want.tx_dest_mac, got.tx_dest_mac);
      if (got.tx_source_mac != want.tx_source_mac)
        report("tx_source_mac", want.tx_source_mac, got.tx_source_mac);
      if (got.tx_start_addr != want.tx_start_addr)
        report("tx_start_addr", want.tx_start_addr, got.tx_start_addr);
      if (got.tx_addr_count != want.tx_addr_count)
        report("tx_addr_count", MacW'(want.tx_addr_count), MacW'(got.tx_addr_count));
      if (got.tx_conflict_addr != want.tx_conflict_addr)
        report("tx_conflict_addr", want.tx_conflict_addr, got.tx_conflict_addr);
      if (got.tx_conflict_count != want.tx_conflict_count)
        report("tx_conflict_count", MacW'(want.tx_conflict_count),
               MacW'(got.tx_conflict_count));
      if (got.phase_now != want.phase_now)
        report("phase_now", MacW'(want.phase_now), MacW'(got.phase_now));
    endfunction

    function int unsigned pending();
      return pending_frames.size();
    endfunction
  endclass

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [MacW-1:0]      cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  in_item_t             in_item_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  out_item_t            out_item_o;

  claim_tracker tracker;
  bit           send_quiet = 1'b0;
  bit           sink_quiet = 1'b0;
  int unsigned  quiet_cycles = 0;

  multicast_address_claim_fsm u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  always #HalfPeriod clk_i = ~clk_i;

  function automatic logic [MacW-1:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MacW-1:0];
  endfunction

  // idle stretches alternate with runs of back-to-back beats
  function automatic int unsigned idle_draw(inout bit quiet);
    if ($urandom_range(0, 49) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, MaxGap);
  endfunction

  function automatic logic [KindW-1:0] known_kind(bit favour_probe);
    logic [KindW-1:0] k;
    case ($urandom_range(0, 2))
      0:       k = RX_KIND_PROBE;
      1:       k = RX_KIND_DEFEND;
      default: k = RX_KIND_ANNOUNCE;
    endcase
    if (favour_probe && $urandom_range(0, 3) != 0) k = RX_KIND_PROBE;
    return k;
  endfunction

  function automatic in_item_t tick_item(logic [RandW-1:0] low);
    in_item_t it;
    it.action        = 1'b0;
    it.rx_kind       = KindW'($urandom);
    it.rx_start_addr = rand48();
    it.rx_addr_count = CountW'($urandom);
    it.rx_sender_mac = rand48();
    it.random_low    = low;
    return it;
  endfunction

  function automatic in_item_t frame_item(logic [KindW-1:0] kind, logic [MacW-1:0] start,
                                          logic [CountW-1:0] count, logic [MacW-1:0] sender);
    in_item_t it;
    it.action        = 1'b1;
    it.rx_kind       = kind;
    it.rx_start_addr = start;
    it.rx_addr_count = count;
    it.rx_sender_mac = sender;
    it.random_low    = RandW'($urandom);
    return it;
  endfunction

  // mostly ticks, plus frames naming the held address, near misses and noise
  function automatic in_item_t random_item(int unsigned probe_hit_pct);
    in_item_t    it;
    int unsigned roll;
    int unsigned hit;
    bit          defending;
    defending = (tracker.claim_phase == PH_DEFENDING);
    hit  = defending ? 12 : probe_hit_pct;
    roll = $urandom_range(0, 99);
    it = frame_item(KindW'($urandom), rand48(), CountW'($urandom), rand48());
    if ($urandom_range(0, 7) == 0)
      it.random_low = RandW'($urandom_range(32'hFFFF, 32'(RandMaxLow) - 1));
    if (roll < 55) begin
      it.action = 1'b0;
    end else if (roll < 55 + hit) begin
      it.rx_kind       = known_kind(defending);
      it.rx_start_addr = tracker.held_addr;
    end else if (roll < 80) begin
      it.rx_kind       = known_kind(defending);
      it.rx_start_addr = tracker.held_addr ^ (MacW'(1) << $urandom_range(0, MacW - 1));
    end
    return it;
  endfunction

  task automatic offer_item(in_item_t it);
    int unsigned gap;
    gap = idle_draw(send_quiet);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_item(it);
  endtask

  task automatic write_reg(logic [CfgIndexW-1:0] idx, logic [MacW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_register(idx, data);
  endtask

  // narrow registers get random upper data bits, which must be ignored
  task automatic apply_settings(logic [LimitW-1:0] limit, logic [IntervalW-1:0] probe_ticks,
                                logic [IntervalW-1:0] announce_ticks,
                                logic [MacW-1:0] mac, logic [CountW-1:0] count);
    logic [MacW-1:0] data;
    data = rand48();
    data[LimitW-1:0] = limit;
    write_reg(REG_PROBE_LIMIT, data);
    data = rand48();
    data[IntervalW-1:0] = probe_ticks;
    write_reg(REG_PROBE_INTERVAL, data);
    data = rand48();
    data[IntervalW-1:0] = announce_ticks;
    write_reg(REG_ANNOUNCE_INTVL, data);
    write_reg(REG_STATION_MAC, mac);
    data = rand48();
    data[CountW-1:0] = count;
    write_reg(REG_ADDRESS_COUNT, data);
    write_reg(CfgIndexW'(REG_SPARE_FIRST + $urandom_range(0, 2)), rand48());
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain_frames();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  // frames that cause no result may still be in flight after the last one arrives
  task automatic settle();
    drain_frames();
    repeat (CfgDrain) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // reset settings: frames ignored while initial, restarts from probing
    offer_item(frame_item(RX_KIND_PROBE, '0, '0, '0));
    offer_item(tick_item(16'hFFFF));
    offer_item(frame_item(RX_KIND_NONE, tracker.held_addr, '1, '1));
    offer_item(frame_item(RX_KIND_LAST, tracker.held_addr, '1, '1));
    offer_item(frame_item(RX_KIND_PROBE, tracker.held_addr ^ MacW'(1), '0, '0));
    offer_item(frame_item(RX_KIND_ANNOUNCE, tracker.held_addr, '0, '0));
    offer_item(tick_item('0));
    offer_item(frame_item(RX_KIND_DEFEND, tracker.held_addr, '1, '0));
    offer_item(tick_item(16'hFE00));
    offer_item(frame_item(RX_KIND_PROBE, tracker.held_addr, '0, '1));
    settle();
    // zero limit and intervals behave as one
    apply_settings('0, '0, '0, '1, '1);
    offer_item(tick_item(16'h1234));
    offer_item(tick_item(RandW'($urandom)));
    offer_item(tick_item(RandW'($urandom)));
    offer_item(frame_item(RX_KIND_PROBE, tracker.held_addr, '1, '1));
    offer_item(frame_item(RX_KIND_PROBE, tracker.held_addr, '0, '0));
    offer_item(frame_item(RX_KIND_DEFEND, tracker.held_addr ^ (MacW'(1) << (MacW - 1)),
                          '0, '0));
    offer_item(frame_item(RX_KIND_LAST, tracker.held_addr, '0, '0));
    offer_item(frame_item(RX_KIND_DEFEND, tracker.held_addr, '0, '0));
    offer_item(tick_item(RandMaxLow));
    offer_item(tick_item(RandW'($urandom)));
    offer_item(frame_item(RX_KIND_ANNOUNCE, tracker.held_addr, '0, '0));
    offer_item(frame_item(RX_KIND_ANNOUNCE, tracker.held_addr, '0, '0));
  endtask

  task automatic random_phase(logic [LimitW-1:0] limit, logic [IntervalW-1:0] probe_ticks,
                              logic [IntervalW-1:0] announce_ticks, logic [MacW-1:0] mac,
                              logic [CountW-1:0] count, int unsigned probe_hit_pct);
    settle();
    apply_settings(limit, probe_ticks, announce_ticks, mac, count);
    for (int unsigned k = 0; k < PhaseItems; k++) begin
      // hold the sender once per phase until the output side has caught up
      if (k == PhaseItems / 2) drain_frames();
      offer_item(random_item(probe_hit_pct));
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_draw(sink_quiet);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_frame(out_item_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("%0t: no beat moved for %0d cycles", $time, StallLimit);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    tracker = new();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    random_phase(4'd15, 20'd1, 20'hFFFFF, rand48(), '0, 0);
    random_phase(4'd1, 20'hFFFFF, 20'd1, '0, '1, 10);
    repeat (4) begin
      random_phase(LimitW'($urandom_range(0, 15)), IntervalW'($urandom_range(0, 8)),
                   IntervalW'($urandom_range(0, 30)), rand48(), CountW'($urandom), 1);
    end
    drain_frames();
    repeat (EndDrain) @(posedge clk_i);
    if (tracker.pending() != 0) begin
      $display("%0t: %0d frames expected, got none", $time, tracker.pending());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hdl/macf_pkg.sv
hdl/macf_front.sv
hdl/macf_queue.sv
hdl/macf_back.sv
hdl/multicast_address_claim_fsm.sv
tb/sv/multicast_address_claim_fsm_test.sv
